[rtl/core/cc_pkg.sv]
// Shared types, constants and helper functions for the ChaCha20 stream XOR block.
`timescale 1ns / 1ps

package cc_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned NUM_WORDS   = 16;
    localparam int unsigned WADDR_W     = $clog2(NUM_WORDS);
    localparam int unsigned KEY_WORDS   = 8;
    localparam int unsigned KEY_W       = KEY_WORDS * WORD_W;
    localparam int unsigned DROUNDS     = 10;
    localparam int unsigned DROUND_W    = $clog2(DROUNDS);
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned POS_W       = 6;
    localparam int unsigned CFG_IDX_W   = 8;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned NUM_KEY_REGS = 4;

    typedef logic [WORD_W-1:0]     t_word;
    typedef logic [WADDR_W-1:0]    t_waddr;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_word SIGMA_0 = 32'h6170_7865;
    localparam t_word SIGMA_1 = 32'h3320_646e;
    localparam t_word SIGMA_2 = 32'h7962_2d32;
    localparam t_word SIGMA_3 = 32'h6b20_6574;

    typedef logic [1:0] t_alu_op;
    localparam t_alu_op ALU_PASS = 2'd0;
    localparam t_alu_op ALU_ADD  = 2'd1;
    localparam t_alu_op ALU_XROT = 2'd2;

    typedef logic [1:0] t_rot;
    localparam t_rot ROT_16 = 2'd0;
    localparam t_rot ROT_12 = 2'd1;
    localparam t_rot ROT_8  = 2'd2;
    localparam t_rot ROT_7  = 2'd3;

    typedef struct packed {
        t_alu_op op;
        t_rot    rot;
    } t_alu_ctl;

    typedef struct packed {
        logic   we;
        t_waddr waddr;
        t_waddr raddr_a;
        t_waddr raddr_b;
    } t_ram_ctl;

    // State word touched by a quarter round; slot 0..3 stands for a, b, c, d.
    // Quarter rounds 0..3 work on columns, 4..7 on diagonals.
    function automatic t_waddr f_qr_word(input logic [2:0] qr, input logic [1:0] slot);
        logic [1:0] lane;
        lane = qr[1:0] + (qr[2] ? slot : 2'd0);
        return {slot, lane};
    endfunction

    // Block input word: constants, key, block counter, then zero nonce words.
    function automatic t_word f_init_word(input t_waddr idx, input logic [KEY_W-1:0] key,
                                          input t_word counter);
        t_word res;
        unique case (idx)
            4'd0:    res = SIGMA_0;
            4'd1:    res = SIGMA_1;
            4'd2:    res = SIGMA_2;
            4'd3:    res = SIGMA_3;
            4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11:
                     res = key[(idx - 4'd4) * WORD_W +: WORD_W];
            4'd12:   res = counter;
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

[rtl/core/cc_ifs.sv]
// Valid/ready channel interfaces for message bytes, result bytes and key writes.
`timescale 1ns / 1ps

interface cc_in_if;
    logic                      valid;
    logic                      ready;
    logic [cc_pkg::BYTE_W-1:0] msg_byte;
    logic                      start_of_message;

    modport source (output valid, output msg_byte, output start_of_message, input ready);
    modport sink   (input valid, input msg_byte, input start_of_message, output ready);
endinterface

interface cc_out_if;
    logic                      valid;
    logic                      ready;
    logic [cc_pkg::BYTE_W-1:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface

interface cc_cfg_if;
    logic              valid;
    logic              ready;
    cc_pkg::t_cfg_idx  index;
    cc_pkg::t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/cc_alu.sv]
// Shared 32-bit unit: pass, add, or xor followed by a fixed left rotation.
`timescale 1ns / 1ps

module cc_alu (
    input  cc_pkg::t_alu_ctl i_ctl,
    input  cc_pkg::t_word    i_x,
    input  cc_pkg::t_word    i_y,
    output cc_pkg::t_word    o_res
);
    import cc_pkg::*;

    t_word xr;
    t_word rot;

    assign xr = i_x ^ i_y;

    always_comb begin
        unique case (i_ctl.rot)
            ROT_16:  rot = {xr[15:0], xr[31:16]};
            ROT_12:  rot = {xr[19:0], xr[31:20]};
            ROT_8:   rot = {xr[23:0], xr[31:24]};
            default: rot = {xr[24:0], xr[31:25]};
        endcase
    end

    always_comb begin
        unique case (i_ctl.op)
            ALU_ADD:  o_res = i_x + i_y;
            ALU_XROT: o_res = rot;
            default:  o_res = i_y;
        endcase
    end

endmodule

[rtl/core/cc_ram.sv]
// Sixteen-word state memory with one write port and two registered read ports.
`timescale 1ns / 1ps

module cc_ram (
    input  logic             i_clk,
    input  cc_pkg::t_ram_ctl i_ctl,
    input  cc_pkg::t_word    i_wdata,
    output cc_pkg::t_word    o_rd_a,
    output cc_pkg::t_word    o_rd_b
);
    import cc_pkg::*;

    t_word r_mem [NUM_WORDS];
    t_word r_rd_a;
    t_word r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_ctl.raddr_a];
        r_rd_b <= r_mem[i_ctl.raddr_b];
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

[rtl/core/cc_core.sv]
// Sequencer that builds keystream blocks through the shared unit and XORs message bytes.
`timescale 1ns / 1ps

module cc_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [cc_pkg::KEY_W-1:0]  i_key,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [cc_pkg::BYTE_W-1:0] i_msg_byte,
    input  logic                      i_start_of_message,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [cc_pkg::BYTE_W-1:0] o_out_byte
);
    import cc_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_LOAD    = 3'd1;
    localparam logic [2:0] S_RND_RD  = 3'd2;
    localparam logic [2:0] S_RND_WR  = 3'd3;
    localparam logic [2:0] S_FIN_RD  = 3'd4;
    localparam logic [2:0] S_FIN_WR  = 3'd5;
    localparam logic [2:0] S_BYTE_RD = 3'd6;
    localparam logic [2:0] S_EMIT    = 3'd7;

    logic [2:0]          r_state, n_state;
    t_waddr              r_idx, n_idx;
    logic [DROUND_W-1:0] r_dround, n_dround;
    logic [2:0]          r_qr, n_qr;
    logic [2:0]          r_op, n_op;
    t_word               r_counter, n_counter;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic                r_blk_ready, n_blk_ready;
    logic [BYTE_W-1:0]   r_msg, n_msg;
    logic                r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]   r_out_byte, n_out_byte;

    t_ram_ctl   ram_ctl;
    t_alu_ctl   alu_ctl;
    t_word      alu_x;
    t_word      alu_y;
    t_word      alu_res;
    t_word      rd_a;
    t_word      rd_b;
    t_word      init_word;
    logic [1:0] dst_slot;
    logic [1:0] src_slot;
    t_waddr     dst_word;
    t_waddr     src_word;
    logic       in_fire;
    logic       out_free;

    cc_alu u_alu (
        .i_ctl (alu_ctl),
        .i_x   (alu_x),
        .i_y   (alu_y),
        .o_res (alu_res)
    );

    cc_ram u_ram (
        .i_clk   (i_clk),
        .i_ctl   (ram_ctl),
        .i_wdata (alu_res),
        .o_rd_a  (rd_a),
        .o_rd_b  (rd_b)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;

    assign init_word = f_init_word(r_idx, i_key, r_counter);
    assign dst_slot  = 2'd0 - r_op[1:0];
    assign src_slot  = dst_slot + 2'd1;
    assign dst_word  = f_qr_word(r_qr, dst_slot);
    assign src_word  = f_qr_word(r_qr, src_slot);

    always_comb begin
        ram_ctl.we      = 1'b0;
        ram_ctl.waddr   = r_idx;
        ram_ctl.raddr_a = r_pos[POS_W-1:2];
        ram_ctl.raddr_b = src_word;
        alu_ctl.op      = ALU_PASS;
        alu_ctl.rot     = r_op[2:1];
        alu_x           = rd_a;
        alu_y           = init_word;

        n_state     = r_state;
        n_idx       = r_idx;
        n_dround    = r_dround;
        n_qr        = r_qr;
        n_op        = r_op;
        n_counter   = r_counter;
        n_pos       = r_pos;
        n_blk_ready = r_blk_ready;
        n_msg       = r_msg;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_byte  = r_out_byte;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_msg = i_msg_byte;
                    n_idx = '0;
                    if (i_start_of_message) begin
                        n_counter   = '0;
                        n_pos       = '0;
                        n_blk_ready = 1'b0;
                    end
                    if (i_start_of_message || r_pos == '0 || !r_blk_ready) begin
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_BYTE_RD;
                    end
                end
            end
            S_LOAD: begin
                ram_ctl.we = 1'b1;
                n_idx      = r_idx + 1'b1;
                if (r_idx == WADDR_W'(NUM_WORDS - 1)) begin
                    n_dround = '0;
                    n_qr     = '0;
                    n_op     = '0;
                    n_state  = S_RND_RD;
                end
            end
            S_RND_RD: begin
                ram_ctl.raddr_a = dst_word;
                n_state         = S_RND_WR;
            end
            S_RND_WR: begin
                ram_ctl.we      = 1'b1;
                ram_ctl.waddr   = dst_word;
                ram_ctl.raddr_a = dst_word;
                alu_ctl.op      = r_op[0] ? ALU_XROT : ALU_ADD;
                alu_y           = rd_b;
                n_op            = r_op + 1'b1;
                n_state         = S_RND_RD;
                if (r_op == 3'd7) begin
                    n_qr = r_qr + 1'b1;
                    if (r_qr == 3'd7) begin
                        n_dround = r_dround + 1'b1;
                        if (r_dround == DROUND_W'(DROUNDS - 1)) begin
                            n_idx   = '0;
                            n_state = S_FIN_RD;
                        end
                    end
                end
            end
            S_FIN_RD: begin
                ram_ctl.raddr_a = r_idx;
                n_state         = S_FIN_WR;
            end
            S_FIN_WR: begin
                ram_ctl.we      = 1'b1;
                ram_ctl.raddr_a = r_idx;
                alu_ctl.op      = ALU_ADD;
                n_idx           = r_idx + 1'b1;
                n_state         = S_FIN_RD;
                if (r_idx == WADDR_W'(NUM_WORDS - 1)) begin
                    n_counter   = r_counter + 1'b1;
                    n_blk_ready = 1'b1;
                    n_state     = S_BYTE_RD;
                end
            end
            S_BYTE_RD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_msg ^ rd_a[{r_pos[1:0], 3'b000} +: BYTE_W];
                    n_pos       = r_pos + 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_counter   <= '0;
            r_pos       <= '0;
            r_blk_ready <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_counter   <= n_counter;
            r_pos       <= n_pos;
            r_blk_ready <= n_blk_ready;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_dround   <= n_dround;
        r_qr       <= n_qr;
        r_op       <= n_op;
        r_msg      <= n_msg;
        r_out_byte <= n_out_byte;
    end

endmodule

[rtl/core/chacha20_stream_xor.sv]
// Top level of the ChaCha20 stream XOR block: key registers and channel wiring.
`timescale 1ns / 1ps

// Each accepted message byte comes back XORed with the next ChaCha20 keystream byte, so
// the block both encrypts and decrypts; the nonce is zero and a start-of-message flag
// restarts the block counter and byte position at zero. A byte that falls inside a held
// keystream block passes through a memory read state and an emit state into the output
// register. The first byte of a message, and every 64th byte after it, first builds a new
// block: it loads the block input, runs the 20 rounds as 640 add or xor-rotate steps (each
// a read state and a write state), and adds the input back in. Block building is paced by
// the single 32-bit add/xor/rotate unit and the one write port of the 16-word state memory.
// A finished result waits in an output register while the next byte is taken. Key writes
// are always accepted, and go to index 0 to 3 only.
module chacha20_stream_xor (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cc_in_if.sink    i_in,
    cc_out_if.source o_out,
    cc_cfg_if.sink   i_cfg
);
    import cc_pkg::*;

    t_cfg_data r_key [NUM_KEY_REGS];
    logic      cfg_hit;

    assign i_cfg.ready = 1'b1;
    assign cfg_hit     = i_cfg.valid && (i_cfg.index < CFG_IDX_W'(NUM_KEY_REGS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_KEY_REGS; i++) begin
                r_key[i] <= '0;
            end
        end else if (cfg_hit) begin
            r_key[i_cfg.index[1:0]] <= i_cfg.data;
        end
    end

    cc_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_key              ({r_key[3], r_key[2], r_key[1], r_key[0]}),
        .i_in_valid         (i_in.valid),
        .o_in_ready         (i_in.ready),
        .i_msg_byte         (i_in.msg_byte),
        .i_start_of_message (i_in.start_of_message),
        .o_out_valid        (o_out.valid),
        .i_out_ready        (o_out.ready),
        .o_out_byte         (o_out.out_byte)
    );

endmodule

[test/chacha20_stream_xor_tb.sv]
// Self-checking testbench for the ChaCha20 stream XOR block with randomized handshakes.
`timescale 1ns / 1ps

module chacha20_stream_xor_tb;
    import cc_pkg::*;

    localparam t_cfg_idx KEY_REG_01 = 8'd0;
    localparam t_cfg_idx KEY_REG_23 = 8'd1;
    localparam t_cfg_idx KEY_REG_45 = 8'd2;
    localparam t_cfg_idx KEY_REG_67 = 8'd3;
    localparam t_cfg_idx LAST_INDEX = '1;
    localparam int RANDOM_BYTES = 750;
    localparam int MAX_MESSAGES = 40;
    localparam int MAX_REPORTS = 10;

    class cipher_byte_scoreboard;
        t_word key_words[KEY_WORDS];
        t_word stream_words[NUM_WORDS];
        t_word mix_words[NUM_WORDS];
        t_word block_count;
        logic [POS_W-1:0] byte_pos;
        bit have_block;
        logic [BYTE_W-1:0] expected_bytes[$];
        int mismatches;
        int bytes_checked;
        int blocks_made;

        function new();
            foreach (key_words[i]) key_words[i] = '0;
            foreach (stream_words[i]) stream_words[i] = '0;
            block_count = '0;
            byte_pos = '0;
            have_block = 1'b0;
            mismatches = 0;
            bytes_checked = 0;
            blocks_made = 0;
        endfunction

        function void write_key(t_cfg_idx idx, t_cfg_data data);
            if (idx < NUM_KEY_REGS) begin
                key_words[2 * int'(idx)] = data[WORD_W-1:0];
                key_words[2 * int'(idx) + 1] = data[CFG_DATA_W-1:WORD_W];
            end
        endfunction

        function t_word rotl(t_word v, int n);
            return (v << n) | (v >> (WORD_W - n));
        endfunction

        function void quarter_round(int a, int b, int c, int d);
            mix_words[a] += mix_words[b];
            mix_words[d] = rotl(mix_words[d] ^ mix_words[a], 16);
            mix_words[c] += mix_words[d];
            mix_words[b] = rotl(mix_words[b] ^ mix_words[c], 12);
            mix_words[a] += mix_words[b];
            mix_words[d] = rotl(mix_words[d] ^ mix_words[a], 8);
            mix_words[c] += mix_words[d];
            mix_words[b] = rotl(mix_words[b] ^ mix_words[c], 7);
        endfunction

        function void make_keystream_block();
            t_word start_words[NUM_WORDS];
            start_words[0] = SIGMA_0;
            start_words[1] = SIGMA_1;
            start_words[2] = SIGMA_2;
            start_words[3] = SIGMA_3;
            for (int i = 0; i < KEY_WORDS; i++) start_words[4 + i] = key_words[i];
            start_words[12] = block_count;
            start_words[13] = '0;
            start_words[14] = '0;
            start_words[15] = '0;
            mix_words = start_words;
            for (int r = 0; r < DROUNDS; r++) begin
                quarter_round(0, 4, 8, 12);
                quarter_round(1, 5, 9, 13);
                quarter_round(2, 6, 10, 14);
                quarter_round(3, 7, 11, 15);
                quarter_round(0, 5, 10, 15);
                quarter_round(1, 6, 11, 12);
                quarter_round(2, 7, 8, 13);
                quarter_round(3, 4, 9, 14);
            end
            for (int i = 0; i < NUM_WORDS; i++) stream_words[i] = mix_words[i] + start_words[i];
            block_count++;
            have_block = 1'b1;
            blocks_made++;
        endfunction

        function void note_input(logic [BYTE_W-1:0] msg, logic som);
            t_word w;
            logic [BYTE_W-1:0] ks;
            logic [BYTE_W-1:0] want;
            if (som) begin
                block_count = '0;
                byte_pos = '0;
                have_block = 1'b0;
            end
            if (byte_pos == '0 || !have_block) make_keystream_block();
            w = stream_words[byte_pos[POS_W-1:2]];
            ks = w[byte_pos[1:0] * BYTE_W +: BYTE_W];
            want = msg ^ ks;
            expected_bytes.insert(expected_bytes.size(), want);
            byte_pos++;
        endfunction

        function void check_result(logic [BYTE_W-1:0] got);
            logic [BYTE_W-1:0] want;
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Result %0d: byte %02h arrived with nothing expected",
                             bytes_checked, got);
            end else begin
                want = expected_bytes.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Result %0d: out_byte expected %02h, got %02h",
                                 bytes_checked, want, got);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit no_idle;
    int bytes_sent;
    int messages_sent;
    int key_settings;
    int out_stall;
    cipher_byte_scoreboard sb;

    cc_in_if  in_if();
    cc_out_if out_if();
    cc_cfg_if cfg_if();

    chacha20_stream_xor DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    initial begin
        out_if.ready = 1'b0;
        out_stall = 0;
        forever begin
            @(negedge i_clk);
            if (no_idle) begin
                out_if.ready = 1'b1;
            end else if (out_stall > 0) begin
                out_if.ready = 1'b0;
                out_stall--;
            end else begin
                out_if.ready = 1'b1;
                out_stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.out_byte);
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic som);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid = 1'b1;
        in_if.msg_byte = b;
        in_if.start_of_message = som;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_input(b, som);
        bytes_sent++;
        if (som) messages_sent++;
    endtask

    task automatic send_message(input int len, input logic with_start);
        for (int i = 0; i < len; i++)
            send_byte(BYTE_W'($urandom_range(0, 255)), with_start && i == 0);
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (sb.expected_bytes.size() != 0 && n < 20000) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    task automatic write_key_reg(input t_cfg_idx idx, input t_cfg_data data);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data = data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        sb.write_key(idx, data);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic write_whole_key(input t_cfg_data k01, input t_cfg_data k23,
                                   input t_cfg_data k45, input t_cfg_data k67);
        write_key_reg(KEY_REG_01, k01);
        write_key_reg(KEY_REG_23, k23);
        write_key_reg(KEY_REG_45, k45);
        write_key_reg(KEY_REG_67, k67);
        key_settings++;
    endtask

    task automatic change_key();
        t_cfg_idx idx;
        idx = t_cfg_idx'($urandom_range(0, NUM_KEY_REGS - 1));
        case ($urandom_range(0, 4))
            0: write_whole_key('0, '0, '0, '0);
            1: write_whole_key('1, '1, '1, '1);
            2: begin
                write_key_reg(idx, {$urandom, $urandom});
                key_settings++;
            end
            3: begin
                write_key_reg(idx, '1);
                key_settings++;
            end
            default: write_whole_key({$urandom, $urandom}, {$urandom, $urandom},
                                     {$urandom, $urandom}, {$urandom, $urandom});
        endcase
        if ($urandom_range(0, 2) == 0)
            write_key_reg(t_cfg_idx'($urandom_range(NUM_KEY_REGS, 255)), {$urandom, $urandom});
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return $urandom_range(1, 6);
        if (r == 9) return $urandom_range(100, 200);
        return $urandom_range(20, 90);
    endfunction

    initial begin
        int phase_bytes;
        int phase_plan;
        logic first_start;
        sb = new();
        no_idle = 1'b0;
        bytes_sent = 0;
        messages_sent = 0;
        key_settings = 1;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.msg_byte = '0;
        in_if.start_of_message = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Zero key straight out of reset, first byte without a start flag.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        wait_drained();

        // The held block must survive a key change; the new key starts with the next block.
        write_whole_key('1, '1, '1, '1);
        write_key_reg(NUM_KEY_REGS, '0);
        write_key_reg(LAST_INDEX, '0);
        send_message(3, 1'b0);
        send_message(4, 1'b1);
        wait_drained();

        write_whole_key(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908,
                        64'h1716_1514_1312_1110, 64'h1f1e_1d1c_1b1a_1918);
        send_message(8, 1'b1);

        while (bytes_sent < RANDOM_BYTES + 21 && messages_sent < MAX_MESSAGES) begin
            wait_drained();
            change_key();
            phase_bytes = bytes_sent;
            phase_plan = $urandom_range(100, 220);
            first_start = ($urandom_range(0, 3) != 0);
            while (bytes_sent - phase_bytes < phase_plan && bytes_sent < RANDOM_BYTES + 21
                   && messages_sent < MAX_MESSAGES) begin
                no_idle = ($urandom_range(0, 4) == 0);
                send_message(pick_length(), first_start);
                first_start = 1'b1;
            end
            no_idle = 1'b0;
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d bytes in %0d messages under %0d key settings (%0d blocks).",
                 bytes_sent, messages_sent, key_settings, sb.blocks_made);
        $display("Checked %0d result bytes: %0d mismatches, %0d still outstanding.",
                 sb.bytes_checked, sb.mismatches, sb.expected_bytes.size());
        if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
